// ===== rtl/sthp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sthp_pkg
// Shared constants and types for the streaming top-n selector.
// ----------------------------------------------------------------------------
package sthp_pkg;

	localparam int MAX_KEEP_DEF = 32;
	localparam int KEY_BITS_DEF = 16;
	localparam int ID_BITS_DEF  = 16;

	localparam int STAMP_W    = 16;
	localparam int TOPN_W     = 6;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [TOPN_W-1:0] TOPN_RESET = TOPN_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_N    = 2'd0,
		REG_KEY_MODE = 2'd1
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SCORE      = 2'd0,
		MODE_POPULARITY = 2'd1,
		MODE_RATING     = 2'd2
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_WRITE = 5'b00100,
		ST_ESCAN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

endpackage

// ===== rtl/streaming_top_n_heap_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_top_n_heap_top
// Keeps the best top_n items of a stream in an on-chip store and reports
// them in descending key order on the item flagged last.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     start & !busy             item_id, score/popularity/rating_key,
//                                      last_item
//  result    out_valid (one cycle)     out_id, out_score, out_popularity,
//                                      out_rating, out_last
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
//  Insert while the store is not full: written on accept, with no store scan.
//  Replacement: one store read per held entry, then at most one write.
//  Ranked output: n results, one read sweep per result.
//  Reset clears control state only; store entries are written before use.
//  Results cannot be held off; cfg_ready is always high.
// ----------------------------------------------------------------------------
module streaming_top_n_heap_top #(
	parameter int MAX_KEEP = sthp_pkg::MAX_KEEP_DEF,
	parameter int KEY_BITS = sthp_pkg::KEY_BITS_DEF,
	parameter int ID_BITS  = sthp_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ID_BITS-1:0]              item_id,
	input  logic [KEY_BITS-1:0]             score_key,
	input  logic [KEY_BITS-1:0]             popularity_key,
	input  logic [KEY_BITS-1:0]             rating_key,
	input  logic                            last_item,
	output logic                            out_valid,
	output logic [ID_BITS-1:0]              out_id,
	output logic [KEY_BITS-1:0]             out_score,
	output logic [KEY_BITS-1:0]             out_popularity,
	output logic [KEY_BITS-1:0]             out_rating,
	output logic                            out_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sthp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sthp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sthp_pkg::*;

	localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int CNT_W = $clog2(MAX_KEEP + 1);

	typedef struct packed {
		logic [STAMP_W-1:0]  stamp;
		logic [KEY_BITS-1:0] rating;
		logic [KEY_BITS-1:0] popularity;
		logic [KEY_BITS-1:0] score;
		logic [ID_BITS-1:0]  id;
	} ent_t;

	function automatic logic [KEY_BITS-1:0] pick_key(input mode_t m, input ent_t e);
		logic [KEY_BITS-1:0] k;
		case (m)
			MODE_POPULARITY: k = e.popularity;
			MODE_RATING:     k = e.rating;
			default:         k = e.score;
		endcase
		return k;
	endfunction

	ent_t mem [MAX_KEEP];

	state_t              state_q;
	logic [TOPN_W-1:0]   top_n_q;
	mode_t               key_mode_q;
	logic [CNT_W-1:0]    held_q;
	logic [STAMP_W-1:0]  arrival_q;
	logic [CNT_W-1:0]    issue_idx_q;
	logic [CNT_W-1:0]    k_q;
	logic                rd_valid_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	ent_t                rd_data_s1;
	logic                first_q;
	logic [MAX_KEEP-1:0] used_q;
	ent_t                item_q;
	logic                last_q;
	logic [IDX_W-1:0]    low_idx_q;
	logic [KEY_BITS-1:0] low_key_q;
	logic [STAMP_W-1:0]  low_stamp_q;
	ent_t                best_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [KEY_BITS-1:0] best_key_q;
	logic                out_valid_q;
	logic                out_last_q;
	ent_t                out_q;

	logic                accept;
	logic [CNT_W-1:0]    cap;
	logic                do_insert;
	logic                issue;
	logic                scan_done;
	logic [KEY_BITS-1:0] cur_key;
	logic [KEY_BITS-1:0] item_key;
	logic                low_upd;
	logic                best_upd;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	ent_t                wr_data;
	ent_t                in_ent;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (top_n_q == '0) begin
			cap = CNT_W'(1);
		end else if (int'(top_n_q) > MAX_KEEP) begin
			cap = CNT_W'(MAX_KEEP);
		end else begin
			cap = CNT_W'(top_n_q);
		end
	end

	assign in_ent.stamp      = arrival_q;
	assign in_ent.rating     = rating_key;
	assign in_ent.popularity = popularity_key;
	assign in_ent.score      = score_key;
	assign in_ent.id         = item_id;

	assign do_insert = held_q < cap;
	assign issue     = ((state_q == ST_SCAN) || (state_q == ST_ESCAN)) && (issue_idx_q < held_q);
	assign scan_done = rd_valid_s1 && ((CNT_W'(rd_idx_s1) + CNT_W'(1)) == held_q);
	assign cur_key   = pick_key(key_mode_q, rd_data_s1);
	assign item_key  = pick_key(key_mode_q, item_q);

	// lowest-ranked entry: later stamp loses a key tie, later slot loses a full tie
	assign low_upd = first_q || (low_key_q > cur_key)
		|| ((low_key_q == cur_key) && (low_stamp_q <= rd_data_s1.stamp));
	assign best_upd = !used_q[rd_idx_s1] && (first_q || (cur_key > best_key_q)
		|| ((cur_key == best_key_q) && (rd_data_s1.stamp < best_q.stamp)));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = held_q[IDX_W-1:0];
		wr_data = in_ent;
		if (accept && do_insert) begin
			wr_en = 1'b1;
		end else if ((state_q == ST_WRITE) && (item_key > low_key_q)) begin
			wr_en   = 1'b1;
			wr_addr = low_idx_q;
			wr_data = item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[issue_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			top_n_q     <= TOPN_RESET;
			key_mode_q  <= MODE_SCORE;
			held_q      <= '0;
			arrival_q   <= '0;
			issue_idx_q <= '0;
			k_q         <= '0;
			rd_valid_s1 <= 1'b0;
			first_q     <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			out_valid_q <= 1'b0;
			if (issue) begin
				issue_idx_q <= issue_idx_q + CNT_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_TOP_N:    top_n_q    <= cfg_data[TOPN_W-1:0];
					REG_KEY_MODE: key_mode_q <= mode_t'(cfg_data[MODE_W-1:0]);
					default:      ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (arrival_q != '1) begin
							arrival_q <= arrival_q + STAMP_W'(1);
						end
						issue_idx_q <= '0;
						first_q     <= 1'b1;
						if (do_insert) begin
							held_q <= held_q + CNT_W'(1);
							if (last_item) begin
								used_q  <= '0;
								k_q     <= '0;
								state_q <= ST_ESCAN;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_valid_s1) begin
						first_q <= 1'b0;
					end
					if (scan_done) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (last_q) begin
						issue_idx_q <= '0;
						first_q     <= 1'b1;
						used_q      <= '0;
						k_q         <= '0;
						state_q     <= ST_ESCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_ESCAN: begin
					if (best_upd && rd_valid_s1) begin
						first_q <= 1'b0;
					end
					if (scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					out_valid_q        <= 1'b1;
					used_q[best_idx_q] <= 1'b1;
					k_q                <= k_q + CNT_W'(1);
					issue_idx_q        <= '0;
					first_q            <= 1'b1;
					if ((k_q + CNT_W'(1)) == held_q) begin
						held_q    <= '0;
						arrival_q <= '0;
						state_q   <= ST_IDLE;
					end else begin
						state_q <= ST_ESCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_idx_q[IDX_W-1:0];
		if (accept) begin
			item_q <= in_ent;
			last_q <= last_item;
		end
		if ((state_q == ST_SCAN) && rd_valid_s1 && low_upd) begin
			low_idx_q   <= rd_idx_s1;
			low_key_q   <= cur_key;
			low_stamp_q <= rd_data_s1.stamp;
		end
		if ((state_q == ST_ESCAN) && rd_valid_s1 && best_upd) begin
			best_q     <= rd_data_s1;
			best_idx_q <= rd_idx_s1;
			best_key_q <= cur_key;
		end
		if (state_q == ST_EMIT) begin
			out_q      <= best_q;
			out_last_q <= (k_q + CNT_W'(1)) == held_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_id         = out_q.id;
	assign out_score      = out_q.score;
	assign out_popularity = out_q.popularity;
	assign out_rating     = out_q.rating;
	assign out_last       = out_last_q;

endmodule
